// ===== sv/int4_int8_block_dot_product_macros.svh =====
// Assertion macros for the checker of the block dot product.
`ifndef INT4_INT8_BLOCK_DOT_PRODUCT_MACROS_SVH
`define INT4_INT8_BLOCK_DOT_PRODUCT_MACROS_SVH

// Same-cycle implication, off during reset.
`define I4DOT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define I4DOT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that follows a reset cycle.
`define I4DOT_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i4dot_pkg.sv =====
// Shared constants, types and float helpers of the block dot product.
`default_nettype none

package i4dot_pkg;

  localparam int BLOCK_SIZE      = 32;
  localparam int LANES           = 4;
  localparam int ITEMS_PER_BLOCK = BLOCK_SIZE / 2 / LANES;
  localparam int POS_W           = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;
  localparam int SUM_W           = 18;
  localparam int VEC_W           = 8 * LANES;
  localparam int SCALE_W         = 16;
  localparam int TDATA_W         = 3 * VEC_W + 2 * SCALE_W;
  localparam int OUT_W           = 32;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int NIBBLE_BIAS     = 8;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;
  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX     = 8'hFF;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SCALE_W-1:0]      dx;
    logic [SCALE_W-1:0]      dy;
    logic                    last;
  } blk_t;

  typedef struct packed {
    logic push;
    blk_t blk;
  } qin_t;

  typedef struct packed {
    logic valid;
    blk_t blk;
  } qout_t;

  typedef enum logic [1:0] {FC_NUM, FC_ZERO, FC_INF, FC_NAN} fcls_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_RND, B_ALIGN, B_ADD, B_NORM, B_ROUND, B_EMIT
  } back_state_t;

  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [9:0] mm;
    logic [3:0] lz;
    logic       found;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && m[i]) begin
        lz = 4'(9 - i);
        found = 1'b1;
      end
    end
    mm = m << (lz + 4'd1);
    if (e == 5'h1F) begin
      half_to_float = {s, EXP_MAX, m, 13'b0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) begin
        half_to_float = {s, 31'b0};
      end else begin
        half_to_float = {s, 8'd113 - {4'b0, lz} - 8'd1, mm, 13'b0};
      end
    end else begin
      half_to_float = {s, {3'b0, e} + 8'd112, m, 13'b0};
    end
  endfunction

  function automatic logic [31:0] int_to_float(input logic signed [SUM_W-1:0] v);
    logic             s;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] norm;
    logic [4:0]       lz;
    logic             found;
    s = v[SUM_W-1];
    mag = s ? (~v + 1'b1) : v;
    lz = 5'd0;
    found = 1'b0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (!found && mag[i]) begin
        lz = 5'(SUM_W - 1 - i);
        found = 1'b1;
      end
    end
    norm = mag << lz;
    if (mag == '0) begin
      int_to_float = 32'd0;
    end else begin
      int_to_float = {s, 8'(127 + SUM_W - 1) - {3'b0, lz},
                      23'(norm[SUM_W-2:0]) << (24 - SUM_W)};
    end
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic found;
    lzc28 = 5'd0;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        lzc28 = 5'(27 - i);
        found = 1'b1;
      end
    end
  endfunction

  function automatic fcls_t classify(input logic [31:0] f);
    if (f[30:23] == EXP_MAX) begin
      classify = (f[22:0] != 23'd0) ? FC_NAN : FC_INF;
    end else if (f[30:23] == 8'd0) begin
      classify = FC_ZERO;
    end else begin
      classify = FC_NUM;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/i4dot_front.sv =====
// Front: takes items, forms lane products and closes integer block sums.
`default_nettype none

module i4dot_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [i4dot_pkg::TDATA_W-1:0] s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  input  wire logic                        q_full,
  output i4dot_pkg::qin_t                  q_in
);

  logic signed [i4dot_pkg::SUM_W-1:0] bsum;
  logic [i4dot_pkg::POS_W-1:0]        pos;
  logic signed [i4dot_pkg::SUM_W-1:0] item_sum;
  logic signed [i4dot_pkg::SUM_W-1:0] sum_next;
  logic [i4dot_pkg::VEC_W-1:0]        nib;
  logic [i4dot_pkg::VEC_W-1:0]        ylo;
  logic [i4dot_pkg::VEC_W-1:0]        yhi;
  logic                               accept;
  logic                               close;

  assign nib = s_axis_tdata[i4dot_pkg::VEC_W-1:0];
  assign ylo = s_axis_tdata[2*i4dot_pkg::VEC_W-1:i4dot_pkg::VEC_W];
  assign yhi = s_axis_tdata[3*i4dot_pkg::VEC_W-1:2*i4dot_pkg::VEC_W];

  always_comb begin
    logic [7:0]         xb;
    logic signed [4:0]  lo;
    logic signed [4:0]  hi;
    logic signed [12:0] plo;
    logic signed [12:0] phi;
    item_sum = '0;
    for (int k = 0; k < i4dot_pkg::LANES; k++) begin
      xb  = nib[8*k +: 8];
      lo  = $signed({1'b0, 4'(xb & i4dot_pkg::NIBBLE_MASK)}) - 5'(i4dot_pkg::NIBBLE_BIAS);
      hi  = $signed({1'b0, xb[7:4]}) - 5'(i4dot_pkg::NIBBLE_BIAS);
      plo = lo * $signed(ylo[8*k +: 8]);
      phi = hi * $signed(yhi[8*k +: 8]);
      item_sum = item_sum + i4dot_pkg::SUM_W'(plo) + i4dot_pkg::SUM_W'(phi);
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sum_next      = bsum + item_sum;
  assign close = (pos == i4dot_pkg::POS_W'(i4dot_pkg::ITEMS_PER_BLOCK - 1)) || s_axis_tlast;

  always_comb begin
    q_in.push     = accept && close;
    q_in.blk.sum  = sum_next;
    q_in.blk.dx   = s_axis_tdata[3*i4dot_pkg::VEC_W +: i4dot_pkg::SCALE_W];
    q_in.blk.dy   = s_axis_tdata[3*i4dot_pkg::VEC_W + i4dot_pkg::SCALE_W +: i4dot_pkg::SCALE_W];
    q_in.blk.last = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bsum <= '0;
      pos  <= '0;
    end else if (accept) begin
      if (close) begin
        bsum <= '0;
        pos  <= '0;
      end else begin
        bsum <= sum_next;
        pos  <= pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/i4dot_queue.sv =====
// Short queue of closed blocks between the front and the float back end.
`default_nettype none

module i4dot_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire i4dot_pkg::qin_t q_in,
  output logic        q_full,
  input  wire logic   pop,
  output i4dot_pkg::qout_t q_out
);

  i4dot_pkg::blk_t           entries [i4dot_pkg::QDEPTH];
  logic [i4dot_pkg::QPTR_W-1:0] wr_ptr;
  logic [i4dot_pkg::QPTR_W-1:0] rd_ptr;
  logic [i4dot_pkg::QPTR_W:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign q_full      = (count == (i4dot_pkg::QPTR_W+1)'(i4dot_pkg::QDEPTH));
  assign q_out.valid = (count != '0);
  assign q_out.blk   = entries[rd_ptr];
  assign do_push     = q_in.push && !q_full;
  assign do_pop      = pop && q_out.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_in.blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/i4dot_back.sv =====
// Back end: scales block sums in float32 and accumulates the row sum.
`default_nettype none

module i4dot_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire i4dot_pkg::qout_t q_out,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [i4dot_pkg::OUT_W-1:0] m_axis_tdata
);

  i4dot_pkg::back_state_t state, state_next;

  logic [31:0]        opa;
  logic [31:0]        opb;
  logic [31:0]        cfy;
  logic [31:0]        acc;
  logic               second;
  logic               last_r;
  logic [47:0]        prod;
  logic signed [9:0]  pexp;
  logic               psign;
  i4dot_pkg::fcls_t   pcls;
  logic [26:0]        amb;
  logic [26:0]        ams;
  logic signed [9:0]  aexp;
  logic               asign;
  logic               asub;
  i4dot_pkg::fcls_t   scls;
  logic [31:0]        sval;
  logic [27:0]        sum;
  logic [4:0]         nlz;
  logic               out_load;

  // Multiply rounding
  logic [23:0]        rm;
  logic               rrb;
  logic               rst_bit;
  logic signed [9:0]  re;
  logic [24:0]        rm25;
  logic [31:0]        mres;

  // Add alignment
  logic [31:0]        big;
  logic [31:0]        sml;
  i4dot_pkg::fcls_t   ca;
  i4dot_pkg::fcls_t   cb;
  logic [7:0]         dexp;
  logic [53:0]        wide;
  logic [26:0]        al;

  // Add rounding
  logic [27:0]        nrm;
  logic [23:0]        am;
  logic signed [9:0]  ae;
  logic [24:0]        am25;
  logic [31:0]        ares;

  always_comb begin
    state_next = state;
    unique case (state)
      i4dot_pkg::B_IDLE:  if (q_out.valid) state_next = i4dot_pkg::B_MUL;
      i4dot_pkg::B_MUL:   state_next = i4dot_pkg::B_RND;
      i4dot_pkg::B_RND:   state_next = second ? i4dot_pkg::B_ALIGN : i4dot_pkg::B_MUL;
      i4dot_pkg::B_ALIGN: state_next = i4dot_pkg::B_ADD;
      i4dot_pkg::B_ADD:   state_next = i4dot_pkg::B_NORM;
      i4dot_pkg::B_NORM:  state_next = i4dot_pkg::B_ROUND;
      i4dot_pkg::B_ROUND: state_next = last_r ? i4dot_pkg::B_EMIT : i4dot_pkg::B_IDLE;
      i4dot_pkg::B_EMIT:  if (!m_axis_tvalid || m_axis_tready) state_next = i4dot_pkg::B_IDLE;
      default:            state_next = i4dot_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      i4dot_pkg::B_IDLE: pop      = q_out.valid;
      i4dot_pkg::B_EMIT: out_load = !m_axis_tvalid || m_axis_tready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Round the 48-bit product to float32.
  always_comb begin
    if (prod[47]) begin
      rm      = prod[47:24];
      rrb     = prod[23];
      rst_bit = |prod[22:0];
      re      = pexp + 10'sd1;
    end else begin
      rm      = prod[46:23];
      rrb     = prod[22];
      rst_bit = |prod[21:0];
      re      = pexp;
    end
    rm25 = {1'b0, rm} + {24'd0, rrb & (rst_bit | rm[0])};
    if (rm25[24]) re = re + 10'sd1;
    case (pcls)
      i4dot_pkg::FC_NAN:  mres = i4dot_pkg::CANON_NAN;
      i4dot_pkg::FC_INF:  mres = {psign, i4dot_pkg::EXP_MAX, 23'd0};
      i4dot_pkg::FC_ZERO: mres = {psign, 31'd0};
      default:            mres = {psign, re[7:0], rm25[24] ? rm25[23:1] : rm25[22:0]};
    endcase
  end

  // Order operands by magnitude and align the smaller one.
  always_comb begin
    if (opb[30:0] > opa[30:0]) begin
      big = opb;
      sml = opa;
    end else begin
      big = opa;
      sml = opb;
    end
    ca   = i4dot_pkg::classify(big);
    cb   = i4dot_pkg::classify(sml);
    dexp = big[30:23] - sml[30:23];
    wide = {(cb == i4dot_pkg::FC_ZERO) ? 24'd0 : {1'b1, sml[22:0]}, 3'b0, 27'd0};
    if (dexp > 8'd27) begin
      al = {26'd0, |wide};
    end else begin
      wide = wide >> dexp[4:0];
      al   = {wide[53:28], wide[27] | (|wide[26:0])};
    end
  end

  // Normalize and round the sum.
  always_comb begin
    nrm  = sum << nlz;
    am   = nrm[27:4];
    ae   = aexp + 10'sd1 - $signed({5'd0, nlz});
    am25 = {1'b0, am} + {24'd0, nrm[3] & ((|nrm[2:0]) | am[0])};
    if (am25[24]) ae = ae + 10'sd1;
    if (scls != i4dot_pkg::FC_NUM) begin
      ares = sval;
    end else if (sum == 28'd0) begin
      ares = {asub ? 1'b0 : asign, 31'd0};
    end else if (ae >= 10'sd255) begin
      ares = {asign, i4dot_pkg::EXP_MAX, 23'd0};
    end else if (ae <= 10'sd0) begin
      ares = {asign, 31'd0};
    end else begin
      ares = {asign, ae[7:0], am25[24] ? am25[23:1] : am25[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i4dot_pkg::B_IDLE;
      acc   <= 32'd0;
    end else begin
      state <= state_next;
      if (state == i4dot_pkg::B_ROUND) acc <= ares;
      if (out_load) acc <= 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      i4dot_pkg::B_IDLE: begin
        opa    <= i4dot_pkg::int_to_float(q_out.blk.sum);
        opb    <= i4dot_pkg::half_to_float(q_out.blk.dx);
        cfy    <= i4dot_pkg::half_to_float(q_out.blk.dy);
        last_r <= q_out.blk.last;
        second <= 1'b0;
      end
      i4dot_pkg::B_MUL: begin
        prod  <= {1'b1, opa[22:0]} * {1'b1, opb[22:0]};
        pexp  <= $signed({2'b0, opa[30:23]}) + $signed({2'b0, opb[30:23]}) - 10'sd127;
        psign <= opa[31] ^ opb[31];
        if (i4dot_pkg::classify(opa) == i4dot_pkg::FC_NAN ||
            i4dot_pkg::classify(opb) == i4dot_pkg::FC_NAN ||
            (i4dot_pkg::classify(opa) == i4dot_pkg::FC_INF &&
             i4dot_pkg::classify(opb) == i4dot_pkg::FC_ZERO) ||
            (i4dot_pkg::classify(opa) == i4dot_pkg::FC_ZERO &&
             i4dot_pkg::classify(opb) == i4dot_pkg::FC_INF)) begin
          pcls <= i4dot_pkg::FC_NAN;
        end else if (i4dot_pkg::classify(opa) == i4dot_pkg::FC_INF ||
                     i4dot_pkg::classify(opb) == i4dot_pkg::FC_INF) begin
          pcls <= i4dot_pkg::FC_INF;
        end else if (i4dot_pkg::classify(opa) == i4dot_pkg::FC_ZERO ||
                     i4dot_pkg::classify(opb) == i4dot_pkg::FC_ZERO) begin
          pcls <= i4dot_pkg::FC_ZERO;
        end else begin
          pcls <= i4dot_pkg::FC_NUM;
        end
      end
      i4dot_pkg::B_RND: begin
        if (!second) begin
          opa    <= mres;
          opb    <= cfy;
          second <= 1'b1;
        end else begin
          opa <= acc;
          opb <= mres;
        end
      end
      i4dot_pkg::B_ALIGN: begin
        amb   <= (ca == i4dot_pkg::FC_ZERO) ? 27'd0 : {1'b1, big[22:0], 3'b0};
        ams   <= al;
        aexp  <= $signed({2'b0, big[30:23]});
        asign <= big[31];
        asub  <= big[31] ^ sml[31];
        if (ca == i4dot_pkg::FC_NAN || cb == i4dot_pkg::FC_NAN ||
            (ca == i4dot_pkg::FC_INF && cb == i4dot_pkg::FC_INF && big[31] != sml[31])) begin
          scls <= i4dot_pkg::FC_NAN;
          sval <= i4dot_pkg::CANON_NAN;
        end else if (ca == i4dot_pkg::FC_INF) begin
          scls <= i4dot_pkg::FC_INF;
          sval <= big;
        end else begin
          scls <= i4dot_pkg::FC_NUM;
          sval <= big;
        end
      end
      i4dot_pkg::B_ADD: begin
        sum <= asub ? ({1'b0, amb} - {1'b0, ams}) : ({1'b0, amb} + {1'b0, ams});
      end
      i4dot_pkg::B_NORM: begin
        nlz <= i4dot_pkg::lzc28(sum);
      end
      default: begin
      end
    endcase
  end

  // Output register: holds the row result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= acc;
  end

endmodule

`default_nettype wire

// ===== sv/int4_int8_block_dot_product.sv =====
// Top level: 4-bit by 8-bit block dot product with float32 row accumulation.
// Front takes one item per cycle while the 4-entry block queue has room.
// Back end works on one closed block at a time (two shared float multiply passes
// and a 4-step float add), plus an emit step on a row's last block.
// Synchronous active-high reset clears the sums, queue and output valid flag.
`default_nettype none

module int4_int8_block_dot_product (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // packed_nibbles, low_half_values, high_half_values, nibble_block_scale,
  // byte_block_scale
  input  wire logic [i4dot_pkg::TDATA_W-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tlast,   // row_end
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [i4dot_pkg::OUT_W-1:0]        m_axis_tdata    // row_dot_bits
);

  i4dot_pkg::qin_t  q_in;
  i4dot_pkg::qout_t q_out;
  logic             q_full;
  logic             pop;

  i4dot_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_in          (q_in)
  );

  i4dot_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_in),
    .q_full (q_full),
    .pop    (pop),
    .q_out  (q_out)
  );

  i4dot_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_out         (q_out),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/i4dot_checker.sv =====
// Port-level checks of the block dot product, bound to the top level.
`default_nettype none
`include "int4_int8_block_dot_product_macros.svh"

module i4dot_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  logic [7:0] pend;

  // Rows ended on the input but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 8'(s_axis_tvalid && s_axis_tready && s_axis_tlast)
                   - 8'(m_axis_tvalid && m_axis_tready);
    end
  end

  `I4DOT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `I4DOT_ASSERT_RST(a_out_reset, !m_axis_tvalid, "result valid right after reset")
  `I4DOT_ASSERT_IMP(a_out_owed, m_axis_tvalid, pend != 8'd0, "result without an ended row")
  `I4DOT_ASSERT_IMP(a_nan_canon, m_axis_tvalid && m_axis_tdata[30:23] == 8'hFF && m_axis_tdata[22:0] != 23'd0, m_axis_tdata == 32'h7FC0_0000, "non-canonical NaN")

endmodule

bind int4_int8_block_dot_product i4dot_checker u_chk (.*);

`default_nettype wire

// ===== sim/int4_int8_block_dot_product_test.sv =====
// Self-checking stream testbench for the 4-bit by 8-bit block dot product.
`default_nettype none

module int4_int8_block_dot_product_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [i4dot_pkg::TDATA_W-1:0] data;
    logic                          last;
    bit                            drain;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [i4dot_pkg::TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [i4dot_pkg::OUT_W-1:0] m_axis_tdata;

  // sender sees whether its beat was still pending after the last edge
  logic s_axis_tready_q = 1'b0;

  int4_int8_block_dot_product u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  beat_t       pending_beats[$];
  logic [31:0] expected_rows[$];
  int          accepted = 0;
  int          errors = 0;
  int          hold_ready = 0;
  bit          long_hold_done = 1'b0;

  // predictor state
  int          blk_acc = 0;
  int          blk_pos = 0;
  logic [31:0] row_acc = 32'h0;

  function automatic logic [31:0] fp16_bits_to_fp32(input logic [15:0] h);
    logic [9:0] m;
    int         e;
    m = h[9:0];
    e = 113;
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, m, 13'b0};
    if (h[14:10] != 5'd0) return {h[15], 8'(h[14:10] + 112), m, 13'b0};
    if (m == 10'd0) return {h[15], 31'b0};
    while (!m[9]) begin
      m = m << 1;
      e--;
    end
    return {h[15], 8'(e - 1), m << 1, 13'b0};
  endfunction

  function automatic real fp32_value(input logic [31:0] f);
    if (f[30:23] == 8'hFF)
      return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
    if (f[30:23] == 8'd0) begin
      if (f[31]) return -(real'(f[22:0]) * 2.0 ** (-149));
      return real'(f[22:0]) * 2.0 ** (-149);
    end
    return $bitstoreal({f[31], 11'(f[30:23] + 896), f[22:0], 29'b0});
  endfunction

  // Round a double to float32, nearest even; NaNs collapse to the canonical one.
  function automatic logic [31:0] round_to_fp32(input real r);
    logic [63:0] b, sig, q, rem, half;
    int          e, sh;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF)
      return (b[51:0] != 0) ? i4dot_pkg::CANON_NAN : {b[63], 8'hFF, 23'b0};
    if (b[62:52] == 11'd0) return {b[63], 31'b0};
    e = int'(b[62:52]) - 1023;
    if (e > 127) return {b[63], 8'hFF, 23'b0};
    sig = {11'b0, 1'b1, b[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    q = sig >> sh;
    half = 64'd1 << (sh - 1);
    rem = sig & ((64'd1 << sh) - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (e < -126) return {b[63], q[30:0]};
    if (q[24]) begin
      q = q >> 1;
      e++;
    end
    if (e > 127) return {b[63], 8'hFF, 23'b0};
    return {b[63], 8'(e + 127), q[22:0]};
  endfunction

  task automatic accumulate_row(input beat_t bt);
    logic [7:0]  xb;
    logic [31:0] t;
    for (int k = 0; k < i4dot_pkg::LANES; k++) begin
      xb = bt.data[8*k +: 8];
      blk_acc += (int'(xb[3:0]) - 8) * int'($signed(bt.data[32 + 8*k +: 8]));
      blk_acc += (int'(xb[7:4]) - 8) * int'($signed(bt.data[64 + 8*k +: 8]));
    end
    blk_pos++;
    if (blk_pos >= i4dot_pkg::ITEMS_PER_BLOCK || bt.last) begin
      t = round_to_fp32(real'(blk_acc));
      t = round_to_fp32(fp32_value(t) * fp32_value(fp16_bits_to_fp32(bt.data[96 +: 16])));
      t = round_to_fp32(fp32_value(t) * fp32_value(fp16_bits_to_fp32(bt.data[112 +: 16])));
      row_acc = round_to_fp32(fp32_value(row_acc) + fp32_value(t));
      blk_acc = 0;
      blk_pos = 0;
    end
    if (bt.last) begin
      expected_rows.push_back(row_acc);
      row_acc = 32'h0;
    end
  endtask

  // idle percentages per phase: none, sender, receiver, both
  function automatic int idle_pct(input bit sender);
    case ((accepted / 250) % 4)
      0: return 0;
      1: return sender ? 65 : 0;
      2: return sender ? 0 : 65;
      default: return 12;
    endcase
  endfunction

  // Sender: present the queue head, hold it until the beat is taken; a drain beat waits until all rows are checked.
  always @(negedge clk) begin
    if (!rst && !(s_axis_tvalid && !s_axis_tready_q)) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)
          && !(pending_beats[0].drain && expected_rows.size() > 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_beats[0].data;
        s_axis_tlast <= pending_beats[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_ready > 0) begin
      hold_ready <= hold_ready - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && accepted >= 1100) begin
      long_hold_done <= 1'b1;
      hold_ready <= 600;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid) begin
      if (s_axis_tready) begin
        s_axis_tready_q <= 1'b1;
        accumulate_row(pending_beats.pop_front());
        accepted <= accepted + 1;
      end else begin
        s_axis_tready_q <= 1'b0;
      end
    end else begin
      s_axis_tready_q <= 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_rows.size() == 0) begin
        $error("row_dot_bits: unexpected beat, actual %h", m_axis_tdata);
        errors++;
      end else if (expected_rows[0] !== m_axis_tdata) begin
        $error("row_dot_bits: expected %h, actual %h", expected_rows[0], m_axis_tdata);
        errors++;
        void'(expected_rows.pop_front());
      end else begin
        void'(expected_rows.pop_front());
      end
    end
  end

  function automatic logic [15:0] rand_scale();
    if ($urandom_range(15) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(20, 10)), 10'($urandom)};
  endfunction

  task automatic add_beat(input logic [31:0] x, lo, hi, input logic [15:0] dx, dy,
                          input logic last, input bit drain = 1'b0);
    beat_t bt;
    bt.data = {dy, dx, hi, lo, x};
    bt.last = last;
    bt.drain = drain;
    pending_beats.push_back(bt);
  endtask

  initial begin
    int n, len;
    bit drain_marked;
    // directed: extremes, special scales, early row end, single-beat row
    add_beat(32'h0, 32'h0, 32'h0, 16'h3C00, 16'h3C00, 1'b0);
    add_beat(32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 16'h1234, 16'h4321, 1'b0);
    add_beat(32'h0000_0000, 32'h8080_8080, 32'h8080_8080, 16'hFFFF, 16'h0000, 1'b0);
    add_beat(32'hF0F0_0F0F, 32'h8000_7F01, 32'h7F80_FF00, 16'h3C00, 16'h3800, 1'b1);
    add_beat(32'h0000_0000, 32'h8080_8080, 32'h8080_8080, 16'h7BFF, 16'h7BFF, 1'b1);
    add_beat(32'h1234_5678, 32'h0102_0304, 32'hFFFE_FDFC, 16'h7C00, 16'h3C00, 1'b1);
    add_beat(32'h8888_8888, 32'h7F7F_7F7F, 32'h8080_8080, 16'h7C00, 16'h0000, 1'b1);
    add_beat(32'h0000_0000, 32'h7F7F_7F7F, 32'h0000_0000, 16'h7E01, 16'h3C00, 1'b1);
    add_beat(32'hFFFF_FFFF, 32'h0101_0101, 32'h0101_0101, 16'h0001, 16'h03FF, 1'b0);
    add_beat(32'h0F0F_0F0F, 32'h7F7F_7F7F, 32'h8080_8080, 16'h8000, 16'hFC00, 1'b1);
    add_beat(32'hFFFF_FFFF, 32'h8080_8080, 32'h8080_8080, 16'h0400, 16'h0200, 1'b1);
    add_beat(32'h0000_0000, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 16'h7BFF, 16'h7BFF, 1'b0);
    add_beat(32'h0000_0000, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 16'h7BFF, 16'h7BFF, 1'b0);
    add_beat(32'h0000_0000, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 16'h7BFF, 16'h7BFF, 1'b0);
    add_beat(32'h0000_0000, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 16'h7BFF, 16'h7BFF, 1'b0);
    add_beat(32'hFFFF_FFFF, 32'h8080_8080, 32'h8080_8080, 16'hFC00, 16'h3C00, 1'b1);
    // random rows, mostly whole blocks, some cut short
    n = 0;
    drain_marked = 1'b0;
    while (n < 1950) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 9) : 4 * $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        add_beat($urandom, $urandom, $urandom, rand_scale(), rand_scale(),
                 i == len - 1, !drain_marked && n >= 1500 && i == 0);
      end
      if (n >= 1500) drain_marked = 1'b1;
      n += len;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_beats.size() == 0 && expected_rows.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/i4dot_pkg.sv
sv/i4dot_front.sv
sv/i4dot_queue.sv
sv/i4dot_back.sv
sv/int4_int8_block_dot_product.sv
sv/i4dot_checker.sv
sim/int4_int8_block_dot_product_test.sv
